### hdl/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and control types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;
    localparam int IN_W   = 32;
    localparam int OUT_W  = 32;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_SET   = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic sweep;
        logic result;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    scroll;
        logic    sweep_last;
        logic    out_free;
    } status_t;

endpackage
`default_nettype wire

### hdl/text_console_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: 80x25 screen of attribute/character cells with
// cursor, control codes, wrap, scroll, clear, set cursor and cell read.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one action per beat; m_axis returns exactly one result
//   beat per action, in order. One action is in flight at a time.
//   A read cell action waits for the registered store read. A put that
//   scrolls blank-fills the new last row (80 cells); clear blank-fills
//   all 2000 cells of the store.
//   Scrolling moves a row offset instead of copying, so only one row is
//   rewritten; the fill sweep writes one cell per cycle through the single
//   store write port.
//   After reset the block sweeps all 2000 cells of the store to blank cells
//   with attribute 0x07 while s_axis_tready is low; the cursor starts at
//   column 0, row 0.
//   A result beat waits in the output register while m_axis_tready is low;
//   the next action is taken meanwhile and stalls only at its own result.
// ----------------------------------------------------------------------------
module text_console_writer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], char_code[9:2], attribute[17:10], col[24:18], row[29:25]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cursor_col[6:0], cursor_row[11:7], cell_data[27:12], scrolled[28]
    output logic [31:0] m_axis_tdata
);

    import tcw_pkg::*;

    cmd_t    cmd;
    status_t st;

    tcw_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .st            (st),
        .cmd           (cmd)
    );

    tcw_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .st            (st)
    );

endmodule
`default_nettype wire

### hdl/tcw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### hdl/tcw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: init sweep, accept, execute, fill sweep, read wait, result.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  tcw_pkg::status_t st,
    output tcw_pkg::cmd_t    cmd
);

    import tcw_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_READ,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                unique case (st.action)
                    ACT_PUT:   state_next = st.scroll ? ST_FILL : ST_DONE;
                    ACT_CLEAR: state_next = ST_FILL;
                    ACT_SET:   state_next = ST_DONE;
                    ACT_READ:  state_next = ST_READ;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_FILL:
            begin
                cmd.sweep = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.result = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

### hdl/tcw_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: item registers, cursor, scroll offset, screen store, fill sweep
// and output register.
// ----------------------------------------------------------------------------
module tcw_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [tcw_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [tcw_pkg::OUT_W-1:0] m_axis_tdata,
    input  tcw_pkg::cmd_t             cmd,
    output tcw_pkg::status_t          st
);

    import tcw_pkg::*;

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] line,
        input logic [ROW_W-1:0] top,
        input logic [COL_W-1:0] col
    );
        logic [ROW_W:0]   sum;
        logic [ROW_W-1:0] phys;
        sum  = {1'b0, line} + {1'b0, top};
        phys = (sum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(sum - (ROW_W + 1)'(ROWS))
                                           : sum[ROW_W-1:0];
        return ADDR_W'(phys) * ADDR_W'(COLS) + ADDR_W'(col);
    endfunction

    action_t           action_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [ATTR_W-1:0] attr_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;

    logic [COL_W-1:0]  cur_col_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ROW_W-1:0]  top_reg;
    logic              scroll_reg;
    logic [ADDR_W-1:0] sweep_addr_reg;
    logic [ADDR_W-1:0] sweep_cnt_reg;
    logic [CELL_W-1:0] fill_reg;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    logic [COL_W:0]    ncol;
    logic [ROW_W:0]    nline;
    logic [COL_W-1:0]  wcol;
    logic [CELL_W-1:0] put_data;
    logic              put_write;
    logic              need_scroll;
    logic [ROW_W-1:0]  top_next;
    logic [COL_W-1:0]  sat_col;
    logic [ROW_W-1:0]  sat_row;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;
    logic [CELL_W-1:0] cell_out;

    always_comb
    begin
        ncol      = {1'b0, cur_col_reg};
        nline     = {1'b0, cur_row_reg};
        wcol      = cur_col_reg;
        put_data  = {attr_reg, char_reg};
        put_write = 1'b0;
        if (char_reg == CH_NEWLINE)
        begin
            ncol  = '0;
            nline = {1'b0, cur_row_reg} + 1'b1;
        end
        else if (char_reg == CH_RETURN)
        begin
            ncol = '0;
        end
        else if (char_reg == CH_BACKSPACE)
        begin
            if (cur_col_reg != '0)
            begin
                wcol      = cur_col_reg - 1'b1;
                ncol      = {1'b0, cur_col_reg} - 1'b1;
                put_data  = {attr_reg, CH_BLANK};
                put_write = 1'b1;
            end
        end
        else
        begin
            put_write = 1'b1;
            ncol      = {1'b0, cur_col_reg} + 1'b1;
        end
        if (ncol >= (COL_W + 1)'(COLS))
        begin
            ncol  = '0;
            nline = nline + 1'b1;
        end
        need_scroll = (nline >= (ROW_W + 1)'(ROWS));
    end

    assign top_next = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
    assign sat_col  = (col_reg > LAST_COL) ? LAST_COL : col_reg;
    assign sat_row  = (row_reg > LAST_ROW) ? LAST_ROW : row_reg;

    assign ram_we    = cmd.sweep || (cmd.exec && action_reg == ACT_PUT && put_write);
    assign ram_waddr = cmd.sweep ? sweep_addr_reg : cell_addr(cur_row_reg, top_reg, wcol);
    assign ram_wdata = cmd.sweep ? fill_reg : put_data;
    assign ram_re    = cmd.exec && action_reg == ACT_READ;
    assign ram_raddr = cell_addr(sat_row, top_reg, sat_col);

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cell_out = (action_reg == ACT_READ) ? ram_rdata : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action_t'(s_axis_tdata[1:0]);
            char_reg   <= s_axis_tdata[9:2];
            attr_reg   <= s_axis_tdata[17:10];
            col_reg    <= s_axis_tdata[24:18];
            row_reg    <= s_axis_tdata[29:25];
        end
        if (cmd.result)
        begin
            m_tdata_reg <= OUT_W'({scroll_reg, cell_out, cur_row_reg, cur_col_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            top_reg        <= '0;
            scroll_reg     <= 1'b0;
            sweep_addr_reg <= '0;
            sweep_cnt_reg  <= LAST_CELL;
            fill_reg       <= {RESET_ATTR, CH_BLANK};
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                unique case (action_reg)
                    ACT_PUT:
                    begin
                        cur_col_reg <= ncol[COL_W-1:0];
                        cur_row_reg <= need_scroll ? LAST_ROW : nline[ROW_W-1:0];
                        scroll_reg  <= need_scroll;
                        if (need_scroll)
                        begin
                            top_reg        <= top_next;
                            sweep_addr_reg <= ADDR_W'(top_reg) * ADDR_W'(COLS);
                            sweep_cnt_reg  <= ADDR_W'(COLS - 1);
                            fill_reg       <= {attr_reg, CH_BLANK};
                        end
                    end
                    ACT_CLEAR:
                    begin
                        cur_col_reg    <= '0;
                        cur_row_reg    <= '0;
                        top_reg        <= '0;
                        scroll_reg     <= 1'b0;
                        sweep_addr_reg <= '0;
                        sweep_cnt_reg  <= LAST_CELL;
                        fill_reg       <= {attr_reg, CH_BLANK};
                    end
                    ACT_SET:
                    begin
                        cur_col_reg <= sat_col;
                        cur_row_reg <= sat_row;
                        scroll_reg  <= 1'b0;
                    end
                    ACT_READ:
                    begin
                        scroll_reg <= 1'b0;
                    end
                    default:
                    begin
                        scroll_reg <= 1'b0;
                    end
                endcase
            end
            if (cmd.sweep)
            begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
                sweep_cnt_reg  <= sweep_cnt_reg - 1'b1;
            end
            if (cmd.result)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign st.action     = action_reg;
    assign st.scroll     = need_scroll;
    assign st.sweep_last = (sweep_cnt_reg == '0);
    assign st.out_free   = !m_tvalid_reg || m_axis_tready;

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_col_reg <= LAST_COL)
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_row_reg <= LAST_ROW)
        else $error("cursor row out of range");

    a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= LAST_ROW)
        else $error("scroll offset out of range");

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sweep && cmd.exec))
        else $error("sweep and execute write in the same cycle");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(cmd.result))
        else $error("output beat raised without a result command");

endmodule
`default_nettype wire
